@@ sv/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

	localparam int RING_DEPTH = 16;
	localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_RUN = 2'd1;
	localparam logic [1:0] MODE_CLR = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] task_id;
		logic [15:0] runtime;
		logic [15:0] steps;
	} cmd_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] system_time;
		logic [31:0] idle_time;
		logic [4:0]  waiting_count;
		logic        done_valid;
		logic [15:0] done_id;
		logic [15:0] done_runtime;
		logic [31:0] done_elapsed;
		logic [31:0] done_completion;
	} result_t;

	// one task record in the ring
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] need;
		logic [15:0] spent;
		logic [31:0] start;
	} entry_t;

	// scheduler state handed to the result register
	typedef struct packed {
		logic        accepted;
		logic [31:0] busy_ticks;
		logic [31:0] empty_ticks;
		logic [4:0]  waiting;
		logic        last_valid;
		logic [15:0] last_id;
		logic [15:0] last_need;
		logic [31:0] last_start;
		logic [31:0] last_finish;
	} stat_t;

endpackage

`default_nettype wire

@@ sv/rrts_ring.sv @@
// ----------------------------------------------------------------------------
// rrts_ring
// Task record store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ring (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [rrts_pkg::PTR_W-1:0] wr_addr,
	input  wire rrts_pkg::entry_t      wr_data,
	input  wire logic                  rd_en,
	input  wire logic [rrts_pkg::PTR_W-1:0] rd_addr,
	output rrts_pkg::entry_t           rd_data
);
	import rrts_pkg::*;

	entry_t mem [RING_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ sv/rrts_sat_inc.sv @@
// ----------------------------------------------------------------------------
// rrts_sat_inc
// Shared 32-bit saturating incrementer for the busy and idle timers.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_sat_inc (
	input  wire logic [31:0] a,
	output logic [31:0]      y
);

	assign y = (&a) ? a : a + 32'd1;

endmodule

`default_nettype wire

@@ sv/rrts_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrts_ctrl
// Command sequencer: ring pointers, timers, completed record, tick loop.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire rrts_pkg::cmd_t cmd,
	output logic                busy,
	output logic                fin,
	output rrts_pkg::stat_t     stat
);
	import rrts_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_EXEC = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [CNT_W-1:0]   count_q;
	logic [15:0]        steps_q;
	logic [31:0]        busy_q, idle_q;
	logic               acc_q;
	logic               last_valid_q;
	logic [15:0]        last_id_q, last_need_q;
	logic [31:0]        last_start_q, last_finish_q;

	logic               accept;
	logic               full;
	logic               add_ok;
	logic               wr_en, rd_en;
	entry_t             wr_data, rd_data;
	logic [31:0]        inc_a, inc_y;
	logic [15:0]        spent_n;
	logic               finished;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign accept   = start && (state_q == S_IDLE);
	assign full     = (count_q == CNT_W'(RING_DEPTH));
	assign add_ok   = accept && (cmd.mode == MODE_ADD) && !full;
	assign spent_n  = (&rd_data.spent) ? rd_data.spent : rd_data.spent + 16'd1;
	assign finished = (spent_n >= rd_data.need);

	// timer unit serves the idle timer in S_RUN and the busy timer in S_EXEC
	assign inc_a = (state_q == S_EXEC) ? busy_q : idle_q;

	rrts_sat_inc u_inc (
		.a (inc_a),
		.y (inc_y)
	);

	assign rd_en = (state_q == S_RUN) && (steps_q != '0) && (count_q != '0);
	assign wr_en = add_ok || ((state_q == S_EXEC) && !finished);

	always_comb begin
		if (state_q == S_EXEC) begin
			wr_data       = rd_data;
			wr_data.spent = spent_n;
		end else begin
			wr_data.id    = cmd.task_id;
			wr_data.need  = cmd.runtime;
			wr_data.spent = '0;
			wr_data.start = busy_q;
		end
	end

	rrts_ring u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			steps_q       <= '0;
			busy_q        <= '0;
			idle_q        <= '0;
			acc_q         <= 1'b1;
			last_valid_q  <= 1'b0;
			last_id_q     <= '0;
			last_need_q   <= '0;
			last_start_q  <= '0;
			last_finish_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						acc_q   <= 1'b1;
						state_q <= S_DONE;
						case (cmd.mode)
							MODE_ADD: begin
								if (full) begin
									acc_q <= 1'b0;
								end else begin
									tail_q  <= next_ptr(tail_q);
									count_q <= count_q + CNT_W'(1);
								end
							end
							MODE_RUN: begin
								steps_q <= cmd.steps;
								state_q <= S_RUN;
							end
							MODE_CLR: begin
								last_valid_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_RUN: begin
					if (steps_q == '0) begin
						state_q <= S_DONE;
					end else if (count_q == '0) begin
						idle_q  <= inc_y;
						state_q <= S_DONE;
					end else begin
						head_q  <= next_ptr(head_q);
						count_q <= count_q - CNT_W'(1);
						steps_q <= steps_q - 16'd1;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					busy_q <= inc_y;
					if (finished) begin
						last_valid_q  <= 1'b1;
						last_id_q     <= rd_data.id;
						last_need_q   <= rd_data.need;
						last_start_q  <= rd_data.start;
						last_finish_q <= inc_y;
					end else begin
						tail_q  <= next_ptr(tail_q);
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_RUN;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign fin  = (state_q == S_DONE);

	assign stat.accepted    = acc_q;
	assign stat.busy_ticks  = busy_q;
	assign stat.empty_ticks = idle_q;
	assign stat.waiting     = 5'(count_q);
	assign stat.last_valid  = last_valid_q;
	assign stat.last_id     = last_id_q;
	assign stat.last_need   = last_need_q;
	assign stat.last_start  = last_start_q;
	assign stat.last_finish = last_finish_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RING_DEPTH))
		else $error("ring count beyond depth");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_W'(RING_DEPTH)) |-> head_q == tail_q)
		else $error("head and tail disagree with count");

	a_exec_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> count_q < CNT_W'(RING_DEPTH))
		else $error("no room to requeue a popped task");

	a_busy_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 busy_q >= $past(busy_q))
		else $error("busy timer went backwards");

	a_exec_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_RUN) && ($past(rd_en, 2)))
		else $error("tick executed without a ring read");
`endif

endmodule

`default_nettype wire

@@ sv/round_robin_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler, one-tick quantum, tasks kept in a ring of records.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   command  | start / busy         | cmd    (rrts_pkg::cmd_t)
//   result   | valid (one cycle)    | result (rrts_pkg::result_t)
//
// Add, clear and unused commands: the result reaches the ports through the
// S_DONE state and then the result register.
// Run command: each served tick is a ring read in S_RUN, then the write-back
// and the busy-timer step through the shared timer incrementer in S_EXEC; a
// closing check in S_RUN and the result load follow.
// busy is high from the transfer until the cycle the result appears.
// Reset clears pointers, timers and the completed record; ring is not cleared.
// The receiver cannot stall: results are shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire rrts_pkg::cmd_t cmd,
	output logic                busy,
	output logic                valid,
	output rrts_pkg::result_t   result
);
	import rrts_pkg::*;

	logic    fin;
	stat_t   stat;
	logic    valid_q;
	result_t result_q;

	rrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.fin    (fin),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= fin;
		end
	end

	// completed-record fields read as zero while no record is held
	always_ff @(posedge clk) begin
		if (fin) begin
			result_q.accepted      <= stat.accepted;
			result_q.system_time   <= stat.busy_ticks;
			result_q.idle_time     <= stat.empty_ticks;
			result_q.waiting_count <= stat.waiting;
			result_q.done_valid    <= stat.last_valid;
			if (stat.last_valid) begin
				result_q.done_id         <= stat.last_id;
				result_q.done_runtime    <= stat.last_need;
				result_q.done_elapsed    <= stat.last_finish - stat.last_start;
				result_q.done_completion <= stat.last_finish;
			end else begin
				result_q.done_id         <= '0;
				result_q.done_runtime    <= '0;
				result_q.done_elapsed    <= '0;
				result_q.done_completion <= '0;
			end
		end
	end

	assign valid  = valid_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ dv/rrts_checker.sv @@
// ----------------------------------------------------------------------------
// rrts_checker
// Watches the command and result channels of the round-robin task scheduler.
// Keeps its own copy of the task ring, timers and completed record, works out
// the result of every command transfer and checks each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire rrts_pkg::cmd_t    cmd,
	input  wire logic              valid,
	input  wire rrts_pkg::result_t result,
	output int                     errors,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rrts_pkg::*;

	entry_t      task_ring[$];
	logic [31:0] sys_ticks;
	logic [31:0] idle_ticks;
	logic        done_held;
	logic [15:0] done_tag;
	logic [15:0] done_need;
	logic [31:0] done_start;
	logic [31:0] done_finish;

	result_t     expected_results[$];
	result_t     want;

	task automatic sched_reset();
		task_ring.delete();
		sys_ticks   = '0;
		idle_ticks  = '0;
		done_held   = 1'b0;
		done_tag    = '0;
		done_need   = '0;
		done_start  = '0;
		done_finish = '0;
	endtask

	// one quantum; returns 0 when the ring was empty
	function automatic bit serve_tick();
		entry_t e;
		if (task_ring.size() == 0) begin
			if (idle_ticks != '1)
				idle_ticks++;
			return 1'b0;
		end
		e = task_ring.pop_front();
		if (sys_ticks != '1)
			sys_ticks++;
		if (e.spent != '1)
			e.spent++;
		if (e.spent >= e.need) begin
			done_held   = 1'b1;
			done_tag    = e.id;
			done_need   = e.need;
			done_start  = e.start;
			done_finish = sys_ticks;
		end else begin
			task_ring.push_back(e);
		end
		return 1'b1;
	endfunction

	function automatic result_t sched_predict(input cmd_t c);
		result_t r;
		entry_t  e;
		int      n;
		r          = '0;
		r.accepted = 1'b1;
		case (c.mode)
			MODE_ADD: begin
				if (task_ring.size() >= RING_DEPTH) begin
					r.accepted = 1'b0;
				end else begin
					e.id    = c.task_id;
					e.need  = c.runtime;
					e.spent = '0;
					e.start = sys_ticks;
					task_ring.push_back(e);
				end
			end
			MODE_RUN: begin
				for (n = 0; n < c.steps; n++)
					if (!serve_tick())
						break;
			end
			MODE_CLR: begin
				done_held = 1'b0;
			end
			default: ;
		endcase
		r.system_time   = sys_ticks;
		r.idle_time     = idle_ticks;
		r.waiting_count = 5'(task_ring.size());
		if (done_held) begin
			r.done_valid      = 1'b1;
			r.done_id         = done_tag;
			r.done_runtime    = done_need;
			r.done_elapsed    = done_finish - done_start;
			r.done_completion = done_finish;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp,
			input logic [31:0] act);
		if (act !== exp) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_reset();
			expected_results.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// results first: a new transfer may land on the edge that ends one
			if (valid) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, got %h", $time, result);
				end else begin
					want = expected_results.pop_front();
					check_field("accepted", 32'(want.accepted), 32'(result.accepted));
					check_field("system_time", want.system_time, result.system_time);
					check_field("idle_time", want.idle_time, result.idle_time);
					check_field("waiting_count", 32'(want.waiting_count),
						32'(result.waiting_count));
					check_field("done_valid", 32'(want.done_valid),
						32'(result.done_valid));
					check_field("done_id", 32'(want.done_id), 32'(result.done_id));
					check_field("done_runtime", 32'(want.done_runtime),
						32'(result.done_runtime));
					check_field("done_elapsed", want.done_elapsed, result.done_elapsed);
					check_field("done_completion", want.done_completion,
						result.done_completion);
				end
			end
			if (start && !busy)
				expected_results.push_back(sched_predict(cmd));
			pending <= expected_results.size();
		end
	end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the round-robin task scheduler: a directed opening
// (empty ring, zero runtime, full ring, zero and maximum steps, clears, the
// unused mode), then bursts of random commands whose mix swings between
// filling and draining the ring. Checking is done in rrts_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rrts_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    valid;
	cmd_t    cmd;
	result_t result;
	int      errors;
	int      pending;

	round_robin_task_scheduler uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.valid  (valid),
		.result (result)
	);

	rrts_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.valid   (valid),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic cmd_t mk(input logic [1:0] mode, input logic [15:0] id,
			input logic [15:0] rt, input logic [15:0] st);
		cmd_t c;
		c.mode    = mode;
		c.task_id = id;
		c.runtime = rt;
		c.steps   = st;
		return c;
	endfunction

	// add_w: percentage of add commands; the rest mostly runs
	function automatic cmd_t rand_cmd(input int add_w);
		cmd_t c;
		int   r;
		c.task_id = 16'($urandom);
		c.runtime = 16'($urandom);
		c.steps   = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < add_w) begin
			c.mode = MODE_ADD;
			r = $urandom_range(0, 199);
			// long tasks are rare
			if (r == 0)
				c.runtime = 16'($urandom);
			else if (r < 30)
				c.runtime = 16'($urandom_range(16, 255));
			else
				c.runtime = 16'($urandom_range(0, 15));
		end else begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				c.mode = MODE_RUN;
				r = $urandom_range(0, 99);
				if (r < 80)
					c.steps = 16'($urandom_range(0, 20));
				else if (r < 97)
					c.steps = 16'($urandom_range(21, 400));
			end else if (r < 9) begin
				c.mode = MODE_CLR;
			end else begin
				c.mode = MODE_UNUSED;
			end
		end
		return c;
	endfunction

	// returns on the edge at which the transfer took place
	task automatic issue(input cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int seg;
		int seg_items;
		int burst;
		int add_w;
		int i;

		start  = 1'b0;
		cmd    = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		issue(mk(MODE_RUN, 16'($urandom), 16'($urandom), 16'd3)); // empty ring goes idle
		issue(mk(MODE_CLR, 16'($urandom), 16'($urandom), 16'($urandom)));
		issue(mk(MODE_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom)));
		issue(mk(MODE_ADD, 16'h0000, 16'h0000, 16'($urandom)));   // zero runtime
		issue(mk(MODE_RUN, 16'($urandom), 16'($urandom), 16'd1));
		issue(mk(MODE_CLR, 16'($urandom), 16'($urandom), 16'($urandom)));
		issue(mk(MODE_ADD, 16'hFFFF, 16'hFFFF, 16'($urandom)));
		for (i = 0; i < RING_DEPTH - 1; i++)
			issue(mk(MODE_ADD, 16'($urandom), 16'($urandom_range(1, 3)),
				16'($urandom)));
		issue(mk(MODE_ADD, 16'hFFFF, 16'($urandom), 16'($urandom))); // ring full, dropped
		issue(mk(MODE_RUN, 16'($urandom), 16'($urandom), 16'd0));
		issue(mk(MODE_RUN, 16'($urandom), 16'($urandom), 16'hFFFF));
		drain();

		for (seg = 0; seg < 8; seg++) begin
			case ($urandom_range(0, 2))
				0: add_w = 25;
				1: add_w = 50;
				default: add_w = 75;
			endcase
			if (seg == 4)
				drain();
			seg_items = 0;
			while (seg_items < 250) begin
				burst = $urandom_range(1, 12);
				for (i = 0; i < burst; i++) begin
					issue(rand_cmd(add_w));
					seg_items++;
				end
				if ($urandom_range(0, 2) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
